### design/hcnc_pkg.sv
// ----------------------------------------------------------------------------
// hcnc_pkg
// Shared types and constants of the hashed chain node cache.
// ----------------------------------------------------------------------------
`default_nettype none
package hcnc_pkg;

   localparam int SLOTS   = 64;
   localparam int BUCKETS = 16;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int BCNT_W  = $clog2(BUCKETS + 1);
   localparam int TAG_W   = 32;

   localparam logic [2:0] ACT_LOOKUP   = 3'd0;
   localparam logic [2:0] ACT_CREATE   = 3'd1;
   localparam logic [2:0] ACT_RESERVE  = 3'd2;
   localparam logic [2:0] ACT_DIRTY    = 3'd3;
   localparam logic [2:0] ACT_MAINTAIN = 3'd4;

   localparam logic [1:0] ALLOC_NONE = 2'd0;
   localparam logic [1:0] ALLOC_USED = 2'd1;
   localparam logic [1:0] ALLOC_FREE = 2'd2;

   localparam logic [1:0] REG_CHAIN_KEEP = 2'd0;
   localparam logic [1:0] REG_TRIM_LEVEL = 2'd1;
   localparam logic [1:0] REG_NODE_LIMIT = 2'd2;

   localparam logic [6:0]  CHAIN_KEEP_RST = 7'd2;
   localparam logic [6:0]  TRIM_LEVEL_RST = 7'd48;
   localparam logic [31:0] NODE_LIMIT_RST = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [SLOT_W-1:0] link;
      logic [1:0]        alloc;
      logic              dirty;
   } mem_word_type;

   typedef struct packed {
      logic [6:0]  chain_keep;
      logic [6:0]  trim_level;
      logic [31:0] node_limit;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [5:0]  slot;
      logic [31:0] node_number;
      logic        hit;
      logic        was_dirty;
      logic        limit_error;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

### design/hcnc_ram.sv
// ----------------------------------------------------------------------------
// hcnc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hcnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### design/hcnc_seq.sv
// ----------------------------------------------------------------------------
// hcnc_seq
// Sequencer: chain walk, allocation, trim and answers over the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none
module hcnc_seq
   import hcnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_node_id,
   input  wire logic        req_move_to_front,
   input  wire logic [5:0]  req_slot_ref,
   input  wire logic        req_use_hint,
   input  wire cfg_type     cfg,
   output rsp_type          rsp
);

   typedef enum logic [4:0] {
      S_IDLE, S_HINT, S_WALK_RD, S_WALK_CHK, S_MTF_PREV, S_MTF_CUR,
      S_ALLOC, S_ALLOC2, S_POP, S_SCAN, S_ATTACH,
      S_TR_BKT, S_TR_RD, S_TR_CHK, S_MARK, S_DONE
   } state_type;

   state_type         state_ff;
   logic [SLOTS-1:0]  valid_ff, used_ff;
   logic              vq_ff;
   logic [SLOT_W-1:0] head_ff [BUCKETS];
   logic [SLOT_W-1:0] free_ff, sp_ff, scan_i_ff;
   logic [CNT_W-1:0]  occ_ff, n_ff;
   logic [BCNT_W-1:0] bkt_ff;
   logic [31:0]       counter_ff;
   logic [31:0]       id_ff, tag_ff;
   logic              mtf_ff, dirty_ff, ret_alloc_ff;
   logic [5:0]        sref_ff;
   logic [SLOT_W-1:0] cur_ff, prev_ff, first_ff;
   mem_word_type      curw_ff, prevw_ff;
   logic [SLOT_W-1:0] ans_slot_ff;
   logic [31:0]       ans_num_ff;
   logic              ans_hit_ff, ans_lim_ff;
   rsp_type           rsp_ff;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr, rd_addr, sp_in;
   mem_word_type      wr_data, ram_q, q;
   logic [BKT_W-1:0]  h;
   logic              sref_ok;

   hcnc_ram #(.WIDTH($bits(mem_word_type)), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign q       = vq_ff ? ram_q : '0;
   assign h       = BKT_W'(tag_ff % BUCKETS);
   assign sref_ok = (32'(sref_ff) < SLOTS);
   assign sp_in   = (sp_ff >= SLOT_W'(SLOTS - 1)) ? SLOT_W'(1) : sp_ff + SLOT_W'(1);
   assign busy    = (state_ff != S_IDLE);
   assign rsp     = rsp_ff;

   always_comb begin
      rd_addr = cur_ff;
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = q;
      case (state_ff)
         S_IDLE: begin
            rd_addr = req_slot_ref[SLOT_W-1:0];
         end
         S_ALLOC2: begin
            rd_addr = free_ff;
         end
         S_MTF_PREV: begin
            wr_en        = 1'b1;
            wr_addr      = prev_ff;
            wr_data      = prevw_ff;
            wr_data.link = curw_ff.link;
         end
         S_MTF_CUR: begin
            wr_en        = 1'b1;
            wr_data      = curw_ff;
            wr_data.link = first_ff;
         end
         S_ATTACH: begin
            wr_en   = 1'b1;
            wr_data = '{tag: tag_ff, link: head_ff[h], alloc: ALLOC_USED, dirty: dirty_ff};
         end
         S_TR_CHK: begin
            if (32'(n_ff) >= 32'(cfg.chain_keep)) begin
               wr_en         = 1'b1;
               wr_data.link  = free_ff;
               wr_data.alloc = ALLOC_FREE;
            end else if (32'(n_ff) + 1 == 32'(cfg.chain_keep)) begin
               wr_en        = 1'b1;
               wr_data.link = '0;
            end
         end
         S_MARK: begin
            wr_addr       = sref_ff[SLOT_W-1:0];
            wr_en         = (sref_ff != 6'd0) && sref_ok;
            wr_data.dirty = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         used_ff    <= '0;
         vq_ff      <= 1'b0;
         free_ff    <= '0;
         sp_ff      <= SLOT_W'(1);
         occ_ff     <= CNT_W'(1);
         counter_ff <= '0;
         rsp_ff     <= '0;
         for (int i = 0; i < BUCKETS; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         vq_ff        <= valid_ff[rd_addr];
         rsp_ff.valid <= 1'b0;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
            if (wr_data.alloc != ALLOC_NONE) begin
               used_ff[wr_addr] <= 1'b1;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  id_ff       <= req_node_id;
                  mtf_ff      <= req_move_to_front;
                  sref_ff     <= req_slot_ref;
                  cur_ff      <= head_ff[BKT_W'(req_node_id % BUCKETS)];
                  first_ff    <= head_ff[BKT_W'(req_node_id % BUCKETS)];
                  prev_ff     <= '0;
                  n_ff        <= '0;
                  ans_slot_ff <= '0;
                  ans_hit_ff  <= 1'b0;
                  ans_lim_ff  <= 1'b0;
                  ans_num_ff  <= '0;
                  dirty_ff    <= (req_action == ACT_CREATE);
                  tag_ff      <= (req_action == ACT_CREATE) ? counter_ff : req_node_id;
                  case (req_action)
                     ACT_LOOKUP: begin
                        ans_num_ff <= req_node_id;
                        state_ff   <= req_use_hint ? S_HINT : S_WALK_RD;
                     end
                     ACT_CREATE: begin
                        ans_num_ff <= counter_ff;
                        ans_lim_ff <= (counter_ff + 32'd1 == cfg.node_limit);
                        counter_ff <= counter_ff + 32'd1;
                        state_ff   <= S_ALLOC;
                     end
                     ACT_RESERVE: begin
                        ans_num_ff <= counter_ff;
                        counter_ff <= counter_ff + 32'd1;
                        state_ff   <= S_DONE;
                     end
                     ACT_DIRTY: begin
                        state_ff <= S_MARK;
                     end
                     ACT_MAINTAIN: begin
                        ret_alloc_ff <= 1'b0;
                        bkt_ff       <= '0;
                        state_ff     <= (32'(occ_ff) >= 32'(cfg.trim_level)) ? S_TR_BKT
                                                                            : S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_HINT: begin
               if (sref_ok && q.alloc == ALLOC_USED && q.tag == id_ff) begin
                  ans_slot_ff <= sref_ff[SLOT_W-1:0];
                  ans_hit_ff  <= 1'b1;
                  state_ff    <= S_DONE;
               end else begin
                  state_ff <= S_WALK_RD;
               end
            end
            S_WALK_RD: begin
               state_ff <= (cur_ff == '0 || 32'(n_ff) >= SLOTS) ? S_ALLOC : S_WALK_CHK;
            end
            S_WALK_CHK: begin
               curw_ff <= q;
               if (q.tag == id_ff) begin
                  ans_slot_ff <= cur_ff;
                  ans_hit_ff  <= 1'b1;
                  state_ff    <= (mtf_ff && prev_ff != '0) ? S_MTF_PREV : S_DONE;
               end else begin
                  prev_ff  <= cur_ff;
                  prevw_ff <= q;
                  cur_ff   <= q.link;
                  n_ff     <= n_ff + CNT_W'(1);
                  state_ff <= S_WALK_RD;
               end
            end
            S_MTF_PREV: begin
               state_ff <= S_MTF_CUR;
            end
            S_MTF_CUR: begin
               head_ff[h] <= cur_ff;
               state_ff   <= S_DONE;
            end
            S_ALLOC: begin
               if (32'(occ_ff) >= SLOTS) begin
                  ret_alloc_ff <= 1'b1;
                  bkt_ff       <= '0;
                  state_ff     <= S_TR_BKT;
               end else begin
                  state_ff <= S_ALLOC2;
               end
            end
            S_ALLOC2: begin
               scan_i_ff <= '0;
               if (32'(occ_ff) >= SLOTS) begin
                  state_ff <= S_DONE;
               end else if (free_ff != '0) begin
                  state_ff <= S_POP;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_POP: begin
               cur_ff   <= free_ff;
               free_ff  <= q.link;
               occ_ff   <= occ_ff + CNT_W'(1);
               state_ff <= S_ATTACH;
            end
            S_SCAN: begin
               sp_ff <= sp_in;
               if (!used_ff[sp_in]) begin
                  cur_ff   <= sp_in;
                  occ_ff   <= occ_ff + CNT_W'(1);
                  state_ff <= S_ATTACH;
               end else if (scan_i_ff == SLOT_W'(SLOTS - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  scan_i_ff <= scan_i_ff + SLOT_W'(1);
               end
            end
            S_ATTACH: begin
               head_ff[h]  <= cur_ff;
               ans_slot_ff <= cur_ff;
               state_ff    <= S_DONE;
            end
            S_TR_BKT: begin
               if (32'(bkt_ff) == BUCKETS) begin
                  state_ff <= ret_alloc_ff ? S_ALLOC2 : S_DONE;
               end else begin
                  cur_ff <= head_ff[bkt_ff[BKT_W-1:0]];
                  n_ff   <= '0;
                  if (cfg.chain_keep == 7'd0) begin
                     head_ff[bkt_ff[BKT_W-1:0]] <= '0;
                  end
                  state_ff <= S_TR_RD;
               end
            end
            S_TR_RD: begin
               if (cur_ff == '0 || 32'(n_ff) >= SLOTS) begin
                  bkt_ff   <= bkt_ff + BCNT_W'(1);
                  state_ff <= S_TR_BKT;
               end else begin
                  state_ff <= S_TR_CHK;
               end
            end
            S_TR_CHK: begin
               if (32'(n_ff) >= 32'(cfg.chain_keep)) begin
                  rsp_ff <= '{valid: 1'b1, kind: 1'b0, slot: 6'(cur_ff),
                              node_number: q.tag, hit: 1'b0, was_dirty: q.dirty,
                              limit_error: 1'b0, last: 1'b0};
                  free_ff <= cur_ff;
                  if (occ_ff != '0) begin
                     occ_ff <= occ_ff - CNT_W'(1);
                  end
               end
               cur_ff   <= q.link;
               n_ff     <= n_ff + CNT_W'(1);
               state_ff <= S_TR_RD;
            end
            S_MARK: begin
               if (sref_ff != 6'd0 && sref_ok) begin
                  ans_slot_ff <= sref_ff[SLOT_W-1:0];
                  ans_num_ff  <= q.tag;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_ff <= '{valid: 1'b1, kind: 1'b1, slot: 6'(ans_slot_ff),
                           node_number: ans_num_ff, hit: ans_hit_ff, was_dirty: 1'b0,
                           limit_error: ans_lim_ff, last: 1'b1};
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### design/hashed_chain_node_cache.sv
// ----------------------------------------------------------------------------
// hashed_chain_node_cache
// Slot manager for a node cache with hashed chains, move to front and trim.
//
// Input: an item is transferred when start is high and busy is low; busy
// stays high until the item's final answer has been issued.
// Results: each result is shown for one cycle with rsp_valid high. Zero or
// more eviction notices (rsp_kind 0) come first, then one final answer with
// rsp_last high, shown in the cycle where busy is low again.
// Steps: a lookup may first check the hinted slot, then walks its bucket's
// chain slot by slot; a hit may move the slot to the front of the chain. A
// miss or a create takes a slot from the free list, else scans for an unused
// slot, trimming all chains first when the cache is full; a maintain trims
// when occupancy has reached the trim level.
// Slot memory is read one entry per cycle, which sets the pace.
// Configuration: APB writes at byte addresses 0, 4 and 8, one wait-free access.
// Reset: synchronous; slot memory reads as zero through per-slot valid bits,
// so no clearing pass runs and items are accepted in the cycle after reset.
// The receiver cannot stall: results leave on their strobe.
// ----------------------------------------------------------------------------
`default_nettype none
module hashed_chain_node_cache
   import hcnc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_node_id,
   input  wire logic        req_move_to_front,
   input  wire logic [5:0]  req_slot_ref,
   input  wire logic        req_use_hint,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic [5:0]       rsp_slot,
   output logic [31:0]      rsp_node_number,
   output logic             rsp_hit,
   output logic             rsp_was_dirty,
   output logic             rsp_limit_error,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type cfg_ff;
   rsp_type rsp;
   logic    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chain_keep <= CHAIN_KEEP_RST;
         cfg_ff.trim_level <= TRIM_LEVEL_RST;
         cfg_ff.node_limit <= NODE_LIMIT_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_CHAIN_KEEP: cfg_ff.chain_keep <= csr_pwdata[6:0];
            REG_TRIM_LEVEL: cfg_ff.trim_level <= csr_pwdata[6:0];
            REG_NODE_LIMIT: cfg_ff.node_limit <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CHAIN_KEEP: csr_prdata = 32'(cfg_ff.chain_keep);
         REG_TRIM_LEVEL: csr_prdata = 32'(cfg_ff.trim_level);
         REG_NODE_LIMIT: csr_prdata = cfg_ff.node_limit;
         default:        csr_prdata = '0;
      endcase
   end

   hcnc_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_node_id       (req_node_id),
      .req_move_to_front (req_move_to_front),
      .req_slot_ref      (req_slot_ref),
      .req_use_hint      (req_use_hint),
      .cfg               (cfg_ff),
      .rsp               (rsp)
   );

   assign rsp_valid       = rsp.valid;
   assign rsp_kind        = rsp.kind;
   assign rsp_slot        = rsp.slot;
   assign rsp_node_number = rsp.node_number;
   assign rsp_hit         = rsp.hit;
   assign rsp_was_dirty   = rsp.was_dirty;
   assign rsp_limit_error = rsp.limit_error;
   assign rsp_last        = rsp.last;

endmodule
`default_nettype wire

### design/hcnc_checker.sv
// ----------------------------------------------------------------------------
// hcnc_checker
// Port-level checks of the result channel against the busy flag.
// ----------------------------------------------------------------------------
`default_nettype none
module hcnc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_kind,
   input wire logic rsp_hit,
   input wire logic rsp_was_dirty,
   input wire logic rsp_last
);

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer accepted but busy did not rise");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final answer shown while busy");

   a_evict_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy && !rsp_kind)
      else $error("eviction notice outside an item");

   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last && !rsp_was_dirty)
      else $error("final answer malformed");

   a_evict_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> !rsp_hit)
      else $error("eviction notice marked as hit");

endmodule

bind hashed_chain_node_cache hcnc_checker u_hcnc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_kind      (rsp_kind),
   .rsp_hit       (rsp_hit),
   .rsp_was_dirty (rsp_was_dirty),
   .rsp_last      (rsp_last)
);
`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed chain node cache. A predictor keeps its
// own copy of slot memory, chains, free list and registers, expands every
// accepted command into eviction notices plus a final answer, and the monitor
// compares each strobed result against the oldest expected entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb
   import hcnc_pkg::*;
;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] node_id;
      logic        mtf;
      logic [5:0]  slot_ref;
      logic        use_hint;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [5:0]  slot;
      logic [31:0] node_number;
      logic        hit;
      logic        was_dirty;
      logic        limit_error;
      logic        last;
   } answer_type;

   localparam int WATCHDOG = 20000;

   logic clock = 0, reset = 1;
   logic start = 0;
   logic [2:0] req_action = 0;
   logic [31:0] req_node_id = 0;
   logic req_move_to_front = 0, req_use_hint = 0;
   logic [5:0] req_slot_ref = 0;
   logic busy, rsp_valid, rsp_kind, rsp_hit, rsp_was_dirty, rsp_limit_error, rsp_last;
   logic [5:0] rsp_slot;
   logic [31:0] rsp_node_number, csr_prdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [3:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;

   hashed_chain_node_cache dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [31:0] m_tag [SLOTS];
   logic [5:0]  m_link [SLOTS];
   logic [1:0]  m_alloc [SLOTS];
   logic        m_dirty [SLOTS];
   logic [5:0]  m_head [BUCKETS];
   int unsigned m_free, m_scan, m_occ;
   logic [31:0] m_counter;
   int unsigned keep_q, level_q;
   logic [31:0] limit_q;

   cmd_type    pending_cmds[$];
   answer_type expected_answers[$];
   int errors = 0, idle_cycles = 0, send_idle = 0;

   function automatic void push_answer(logic kind, logic [5:0] slot, logic [31:0] num,
                                       logic hit, logic dirty, logic lim, logic last);
      answer_type a;
      a = '{kind, slot, num, hit, dirty, lim, last};
      expected_answers.push_back(a);
   endfunction

   function automatic void trim_chains();
      int unsigned c, n, nxt;
      for (int h = 0; h < BUCKETS; h++) begin
         c = m_head[h];
         n = 0;
         if (keep_q == 0) m_head[h] = 0;
         while (c != 0 && n < SLOTS) begin
            nxt = m_link[c];
            if (n >= keep_q) begin
               push_answer(0, 6'(c), m_tag[c], 0, m_dirty[c], 0, 0);
               m_alloc[c] = ALLOC_FREE;
               m_link[c] = 6'(m_free);
               m_free = c;
               if (m_occ > 0) m_occ--;
            end else if (n + 1 == keep_q) begin
               m_link[c] = 0;
            end
            c = nxt;
            n++;
         end
      end
   endfunction

   function automatic int unsigned grab_slot();
      int unsigned c;
      c = 0;
      if (m_occ >= SLOTS) trim_chains();
      if (m_occ >= SLOTS) return 0;
      if (m_free != 0) begin
         c = m_free;
         m_free = m_link[c];
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            m_scan = (m_scan >= SLOTS - 1) ? 1 : m_scan + 1;
            if (m_alloc[m_scan] == ALLOC_NONE) begin
               c = m_scan;
               break;
            end
         end
         if (c == 0) return 0;
      end
      m_alloc[c] = ALLOC_USED;
      m_occ++;
      return c;
   endfunction

   function automatic void link_slot(int unsigned c, logic [31:0] tag, logic dirty);
      m_tag[c] = tag;
      m_dirty[c] = dirty;
      m_link[c] = m_head[tag % BUCKETS];
      m_head[tag % BUCKETS] = 6'(c);
   endfunction

   function automatic void predict_cache(cmd_type cmd);
      int unsigned h, first, c, prev, n;
      logic [31:0] num;
      case (cmd.action)
         ACT_LOOKUP: begin
            h = cmd.node_id % BUCKETS;
            first = m_head[h];
            c = first;
            prev = 0;
            n = 0;
            if (cmd.use_hint && m_alloc[cmd.slot_ref] == ALLOC_USED
                && m_tag[cmd.slot_ref] == cmd.node_id) begin
               push_answer(1, cmd.slot_ref, cmd.node_id, 1, 0, 0, 1);
               return;
            end
            while (c != 0 && n < SLOTS) begin
               if (m_tag[c] == cmd.node_id) begin
                  if (cmd.mtf && prev != 0) begin
                     m_link[prev] = m_link[c];
                     m_link[c] = 6'(first);
                     m_head[h] = 6'(c);
                  end
                  push_answer(1, 6'(c), cmd.node_id, 1, 0, 0, 1);
                  return;
               end
               prev = c;
               c = m_link[c];
               n++;
            end
            c = grab_slot();
            if (c != 0) link_slot(c, cmd.node_id, 0);
            push_answer(1, 6'(c), cmd.node_id, 0, 0, 0, 1);
         end
         ACT_CREATE: begin
            num = m_counter;
            c = grab_slot();
            if (c != 0) link_slot(c, num, 1);
            m_counter = m_counter + 1;
            push_answer(1, 6'(c), num, 0, 0, m_counter == limit_q, 1);
         end
         ACT_RESERVE: begin
            push_answer(1, 0, m_counter, 0, 0, 0, 1);
            m_counter = m_counter + 1;
         end
         ACT_DIRTY: begin
            if (cmd.slot_ref == 0) push_answer(1, 0, 0, 0, 0, 0, 1);
            else begin
               m_dirty[cmd.slot_ref] = 1;
               push_answer(1, cmd.slot_ref, m_tag[cmd.slot_ref], 0, 0, 0, 1);
            end
         end
         ACT_MAINTAIN: begin
            if (m_occ >= level_q) trim_chains();
            push_answer(1, 0, 0, 0, 0, 0, 1);
         end
         default: push_answer(1, 0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!(start && !busy) && start) begin
         // hold
      end else begin
         if (start && !busy) predict_cache(pending_cmds.pop_front());
         if (pending_cmds.size() > 0 && !(send_idle > 0 && $urandom_range(99) < send_idle)) begin
            start <= 1;
            req_action <= pending_cmds[0].action;
            req_node_id <= pending_cmds[0].node_id;
            req_move_to_front <= pending_cmds[0].mtf;
            req_slot_ref <= pending_cmds[0].slot_ref;
            req_use_hint <= pending_cmds[0].use_hint;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_kind, rsp_slot, rsp_node_number, rsp_hit, rsp_was_dirty,
                 rsp_limit_error, rsp_last};
         if (expected_answers.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer: %p", got);
         end else begin
            want = expected_answers.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_psel) idle_cycles <= 0;
      else if (pending_cmds.size() > 0 || expected_answers.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_CHAIN_KEEP: keep_q = value[6:0];
         REG_TRIM_LEVEL: level_q = value[6:0];
         default: limit_q = value;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || busy || expected_answers.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic cmd_type make_cmd(logic [2:0] act, logic [31:0] id, logic mtf,
                                        logic [5:0] sref, logic hint);
      cmd_type c;
      c = '{act, id, mtf, sref, hint};
      return c;
   endfunction

   function automatic logic [31:0] pick_id();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {$urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(15);
         default: return $urandom_range(40);
      endcase
   endfunction

   function automatic cmd_type random_cmd();
      int r;
      r = $urandom_range(99);
      return make_cmd(r < 55 ? ACT_LOOKUP : r < 70 ? ACT_CREATE : r < 78 ? ACT_RESERVE :
                      r < 88 ? ACT_DIRTY : r < 96 ? ACT_MAINTAIN : 3'($urandom_range(5, 7)),
                      pick_id(), $urandom_range(1), $urandom_range(63), $urandom_range(1));
   endfunction

   initial begin
      int idle_mix [4];
      logic [6:0] keeps [4];
      logic [6:0] levels [4];
      idle_mix = '{0, 72, 0, 27};
      keeps = '{7'd64, 7'd1, 7'd0, 7'd3};
      levels = '{7'd64, 7'd1, 7'd20, 7'd48};
      for (int i = 0; i < SLOTS; i++) begin
         m_tag[i] = 0; m_link[i] = 0; m_alloc[i] = ALLOC_NONE; m_dirty[i] = 0;
      end
      for (int i = 0; i < BUCKETS; i++) m_head[i] = 0;
      m_free = 0; m_scan = 1; m_occ = 1; m_counter = 0;
      keep_q = CHAIN_KEEP_RST; level_q = TRIM_LEVEL_RST; limit_q = NODE_LIMIT_RST;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'h0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'h10, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'h20, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'h0, 1, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'h10, 1, 2, 1));
      pending_cmds.push_back(make_cmd(ACT_LOOKUP, 32'h10, 0, 6'd63, 1));
      pending_cmds.push_back(make_cmd(ACT_CREATE, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_RESERVE, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_DIRTY, 0, 0, 1, 0));
      pending_cmds.push_back(make_cmd(ACT_DIRTY, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_DIRTY, 0, 0, 6'd63, 0));
      pending_cmds.push_back(make_cmd(ACT_MAINTAIN, 0, 0, 0, 0));
      for (int a = 5; a < 8; a++)
         pending_cmds.push_back(make_cmd(3'(a), 32'hFFFF_FFFF, 1, 6'd63, 1));
      wait_drained();
      csr_write(REG_NODE_LIMIT, 32'd4);
      csr_write(REG_TRIM_LEVEL, 7'd1);
      csr_write(REG_CHAIN_KEEP, 7'd1);
      pending_cmds.push_back(make_cmd(ACT_CREATE, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_MAINTAIN, 0, 0, 0, 0));
      wait_drained();
      csr_write(REG_NODE_LIMIT, 32'hFFFF_FFFF);
      // random phases
      for (int p = 0; p < 4; p++) begin
         send_idle = idle_mix[p];
         csr_write(REG_CHAIN_KEEP, keeps[p]);
         csr_write(REG_TRIM_LEVEL, levels[p]);
         csr_write(REG_NODE_LIMIT, p == 2 ? m_counter + 3 : $urandom);
         for (int i = 0; i < 88; i++) pending_cmds.push_back(random_cmd());
         wait_drained();
      end
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### filelist.f
design/hcnc_pkg.sv
design/hcnc_ram.sv
design/hcnc_seq.sv
design/hashed_chain_node_cache.sv
design/hcnc_checker.sv
bench/tb.sv
